// ----- hw/rtl/lcs_pkg.sv -----
// Package with the shared types and constants of the loop control stack.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    localparam int unsigned PC_WIDTH = 16;
    localparam int unsigned DATA_WIDTH = 64;

    typedef enum logic [3:0] {
        FN_COUNTED_BEGIN = 4'd0,
        FN_RANGED_BEGIN  = 4'd1,
        FN_AGAIN         = 4'd2,
        FN_NEXT          = 4'd3,
        FN_READ_I        = 4'd4,
        FN_READ_J        = 4'd5,
        FN_READ_K        = 4'd6,
        FN_JUMP_ZERO     = 4'd7,
        FN_JUMP          = 4'd8
    } func_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_DOWN = 2'd1,
        CELL_SHIFT_UP   = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [3:0]                   func;
        logic [PC_WIDTH-1:0]          pc;
        logic signed [DATA_WIDTH-1:0] count_or_start;
        logic signed [DATA_WIDTH-1:0] limit;
        logic signed [DATA_WIDTH-1:0] step;
        logic signed [DATA_WIDTH-1:0] condition;
        logic [PC_WIDTH-1:0]          target;
    } cmd_t;

    typedef struct packed {
        logic                         redirect;
        logic [PC_WIDTH-1:0]          redirect_pc;
        logic                         value_valid;
        logic signed [DATA_WIDTH-1:0] value;
        logic [1:0]                   error;
    } result_t;

    // One loop frame. The limit is kept as limit minus step so that a loop
    // end needs only one compare.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] counter;
        logic signed [DATA_WIDTH-1:0] bound;
        logic signed [DATA_WIDTH-1:0] step;
        logic                         step_pos;
        logic [PC_WIDTH-1:0]          return_pc;
    } frame_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcs_cell.sv -----
// One stack cell that holds a loop frame and shifts it to either neighbor.
`timescale 1ns / 1ps
`default_nettype none

module lcs_cell (
    input  wire logic              clk,
    input  wire lcs_pkg::cell_op_t op,
    input  wire lcs_pkg::frame_t   from_above,
    input  wire lcs_pkg::frame_t   from_below,
    output lcs_pkg::frame_t        frame
);
    import lcs_pkg::*;

    frame_t frame_reg;
    frame_t frame_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:       frame_next = frame_reg;
            CELL_SHIFT_DOWN: frame_next = from_above;
            CELL_SHIFT_UP:   frame_next = from_below;
            default:         frame_next = frame_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame = frame_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/loop_control_stack_core.sv -----
// Top level of the loop control stack: command decode, depth count and the row of frame cells.
//
// Channel   Direction  Handshake             Payload
// command   in         start high, busy low  cmd (cmd_t)
// result    out        done for one cycle    result (result_t)
//
// Each request is decoded in the cycle it is accepted and its result appears with done
// in the next cycle, so one request is taken every cycle; busy stays low.
// The top frame sits in the first cell, so a loop end needs one compare and one add.
// Reset clears the frame count and the done strobe; frame contents are undefined until pushed.
// The receiver cannot stall; a result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module loop_control_stack_core #(
    parameter int unsigned LOOP_DEPTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire lcs_pkg::cmd_t    cmd,
    output logic                  done,
    output lcs_pkg::result_t      result
);
    import lcs_pkg::*;

    localparam int unsigned DW = $clog2(LOOP_DEPTH + 1);

    logic              accept;
    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;
    cell_op_t          cell_op [LOOP_DEPTH];
    frame_t            cell_q [LOOP_DEPTH];
    frame_t            new_frame;
    logic              push;
    logic              pop;
    logic              load_top;
    logic              full;
    logic              empty;
    logic              top_step_pos;
    logic              cont;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (depth_reg == DW'(LOOP_DEPTH));
    assign empty  = (depth_reg == '0);
    assign top_step_pos = cell_q[0].step_pos;
    assign cont = top_step_pos ? (cell_q[0].counter < cell_q[0].bound)
                               : (cell_q[0].counter > cell_q[0].bound);

    always_comb
    begin
        result_next = '0;
        push        = 1'b0;
        pop         = 1'b0;
        load_top    = 1'b0;
        new_frame   = cell_q[0];
        depth_next  = depth_reg;
        case (cmd.func)
            FN_COUNTED_BEGIN:
            begin
                new_frame.counter   = '0;
                new_frame.bound     = cmd.count_or_start - 64'sd1;
                new_frame.step      = 64'sd1;
                new_frame.step_pos  = 1'b1;
                new_frame.return_pc = cmd.pc;
                if (full)
                begin
                    result_next.error = ERR_OVERFLOW;
                end
                else
                begin
                    push       = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
            end
            FN_RANGED_BEGIN:
            begin
                new_frame.counter   = cmd.count_or_start;
                new_frame.bound     = cmd.limit - cmd.step;
                new_frame.step      = cmd.step;
                new_frame.step_pos  = !cmd.step[DATA_WIDTH-1] && (cmd.step != '0);
                new_frame.return_pc = cmd.pc;
                if (full)
                begin
                    result_next.error = ERR_OVERFLOW;
                end
                else
                begin
                    push       = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
            end
            FN_AGAIN, FN_NEXT:
            begin
                new_frame.counter = cell_q[0].counter + cell_q[0].step;
                if (empty)
                begin
                    result_next.error = ERR_UNDERFLOW;
                end
                else if (cont)
                begin
                    load_top                = 1'b1;
                    result_next.redirect    = 1'b1;
                    result_next.redirect_pc = cell_q[0].return_pc;
                end
                else
                begin
                    pop        = 1'b1;
                    depth_next = depth_reg - DW'(1);
                end
            end
            FN_READ_I:
            begin
                if (depth_reg < DW'(1))
                begin
                    result_next.error = ERR_UNDERFLOW;
                end
                else
                begin
                    result_next.value_valid = 1'b1;
                    result_next.value       = cell_q[0].counter;
                end
            end
            FN_READ_J:
            begin
                if (depth_reg < DW'(2))
                begin
                    result_next.error = ERR_UNDERFLOW;
                end
                else
                begin
                    result_next.value_valid = 1'b1;
                    result_next.value       = cell_q[1].counter;
                end
            end
            FN_READ_K:
            begin
                if (depth_reg < DW'(3))
                begin
                    result_next.error = ERR_UNDERFLOW;
                end
                else
                begin
                    result_next.value_valid = 1'b1;
                    result_next.value       = cell_q[2].counter;
                end
            end
            FN_JUMP_ZERO:
            begin
                if (cmd.condition == '0)
                begin
                    result_next.redirect    = 1'b1;
                    result_next.redirect_pc = cmd.target;
                end
            end
            FN_JUMP:
            begin
                result_next.redirect    = 1'b1;
                result_next.redirect_pc = cmd.target;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
        if (!accept)
        begin
            push       = 1'b0;
            pop        = 1'b0;
            load_top   = 1'b0;
            depth_next = depth_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LOOP_DEPTH; g++)
        begin : g_cell
            frame_t above;
            frame_t below;

            if (g == 0)
            begin : g_first
                assign above = new_frame;
            end
            else
            begin : g_mid
                assign above = cell_q[g-1];
            end

            if (g == LOOP_DEPTH - 1)
            begin : g_last
                assign below = '0;
            end
            else
            begin : g_inner
                assign below = cell_q[g+1];
            end

            always_comb
            begin
                if (push || (load_top && (g == 0)))
                begin
                    cell_op[g] = CELL_SHIFT_DOWN;
                end
                else if (pop)
                begin
                    cell_op[g] = CELL_SHIFT_UP;
                end
                else
                begin
                    cell_op[g] = CELL_HOLD;
                end
            end

            lcs_cell u_cell (
                .clk        (clk),
                .op         (cell_op[g]),
                .from_above (above),
                .from_below (below),
                .frame      (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted request produced no result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a request");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(LOOP_DEPTH))
        else $error("frame count beyond stack depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.error == ERR_OVERFLOW)) |-> (depth_reg == DW'(LOOP_DEPTH)))
        else $error("overflow reported while stack not full");

    a_redirect_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.redirect) |-> (!result.value_valid && (result.error == ERR_NONE)))
        else $error("redirect together with an index read or error");
`endif

endmodule

`default_nettype wire

// ----- bench/loop_control_stack_core_tb.sv -----
// Testbench for the loop control stack core: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module loop_control_stack_core_tb;
    import lcs_pkg::*;

    localparam int unsigned LOOP_DEPTH = 8;
    localparam int unsigned ITEM_COUNT = 1050;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [3:0] FN_UNUSED_TOP = 4'hF;
    localparam logic signed [DATA_WIDTH-1:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] S64_MIN = 64'sh8000_0000_0000_0000;

    class frame_stack_scoreboard;
        logic signed [DATA_WIDTH-1:0] counters [LOOP_DEPTH];
        logic signed [DATA_WIDTH-1:0] limits [LOOP_DEPTH];
        logic signed [DATA_WIDTH-1:0] steps [LOOP_DEPTH];
        logic [PC_WIDTH-1:0] return_pcs [LOOP_DEPTH];
        int unsigned live_frames;
        int unsigned fails;
        result_t expected_results [$];

        function new();
            live_frames = 0;
            fails = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            fails++;
        endtask

        function err_t push_frame(logic signed [DATA_WIDTH-1:0] ctr,
                                  logic signed [DATA_WIDTH-1:0] lim,
                                  logic signed [DATA_WIDTH-1:0] stp,
                                  logic [PC_WIDTH-1:0] ret_pc);
            if (live_frames >= LOOP_DEPTH)
                return ERR_OVERFLOW;
            counters[live_frames] = ctr;
            limits[live_frames] = lim;
            steps[live_frames] = stp;
            return_pcs[live_frames] = ret_pc;
            live_frames++;
            return ERR_NONE;
        endfunction

        function result_t predict_result(cmd_t c);
            result_t r;
            int unsigned top;
            int unsigned lvl;
            logic signed [DATA_WIDTH-1:0] cur;
            logic signed [DATA_WIDTH-1:0] inc;
            logic signed [DATA_WIDTH-1:0] bound;
            r = '0;
            case (c.func)
                FN_COUNTED_BEGIN: r.error = push_frame('0, c.count_or_start, 64'sd1, c.pc);
                FN_RANGED_BEGIN: r.error = push_frame(c.count_or_start, c.limit, c.step, c.pc);
                FN_AGAIN, FN_NEXT:
                begin
                    if (live_frames == 0)
                        r.error = ERR_UNDERFLOW;
                    else
                    begin
                        top = live_frames - 1;
                        cur = counters[top];
                        inc = steps[top];
                        bound = limits[top] - steps[top];
                        if ((inc > 0) ? (cur < bound) : (cur > bound))
                        begin
                            counters[top] = cur + inc;
                            r.redirect = 1'b1;
                            r.redirect_pc = return_pcs[top];
                        end
                        else
                            live_frames = top;
                    end
                end
                FN_READ_I, FN_READ_J, FN_READ_K:
                begin
                    lvl = (c.func == FN_READ_I) ? 1 : (c.func == FN_READ_J) ? 2 : 3;
                    if (live_frames < lvl)
                        r.error = ERR_UNDERFLOW;
                    else
                    begin
                        r.value_valid = 1'b1;
                        r.value = counters[live_frames - lvl];
                    end
                end
                FN_JUMP_ZERO:
                begin
                    if (c.condition == 0)
                    begin
                        r.redirect = 1'b1;
                        r.redirect_pc = c.target;
                    end
                end
                FN_JUMP:
                begin
                    r.redirect = 1'b1;
                    r.redirect_pc = c.target;
                end
                default: r = '0;
            endcase
            return r;
        endfunction

        function void note_request(cmd_t c);
            expected_results.push_back(predict_result(c));
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (got.redirect !== want.redirect)
                report($sformatf("redirect got %0b want %0b", got.redirect, want.redirect));
            if (got.redirect_pc !== want.redirect_pc)
                report($sformatf("redirect_pc got %h want %h", got.redirect_pc, want.redirect_pc));
            if (got.value_valid !== want.value_valid)
                report($sformatf("value_valid got %0b want %0b", got.value_valid,
                                 want.value_valid));
            if (got.value !== want.value)
                report($sformatf("value got %0d want %0d", got.value, want.value));
            if (got.error !== want.error)
                report($sformatf("error got %0d want %0d", got.error, want.error));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    result_t result;

    frame_stack_scoreboard sb = new();
    bit idle_on;
    int unsigned requests_sent;
    int unsigned cycles;

    loop_control_stack_core #(
        .LOOP_DEPTH(LOOP_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [DATA_WIDTH-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        c.func = FN_JUMP;
        c.pc = PC_WIDTH'($urandom);
        c.count_or_start = rand64();
        c.limit = rand64();
        c.step = rand64();
        c.condition = rand64();
        c.target = PC_WIDTH'($urandom);
        return c;
    endfunction

    function automatic cmd_t make_cmd(logic [3:0] f, logic [PC_WIDTH-1:0] p,
                                      logic signed [DATA_WIDTH-1:0] a,
                                      logic signed [DATA_WIDTH-1:0] b,
                                      logic signed [DATA_WIDTH-1:0] s,
                                      logic signed [DATA_WIDTH-1:0] cond,
                                      logic [PC_WIDTH-1:0] tgt);
        cmd_t c;
        c.func = f;
        c.pc = p;
        c.count_or_start = a;
        c.limit = b;
        c.step = s;
        c.condition = cond;
        c.target = tgt;
        return c;
    endfunction

    task automatic send_cmd(cmd_t c);
        if (idle_on)
            while ($urandom_range(99) < 26)
            begin
                @(negedge clk);
                start <= 1'b0;
                @(posedge clk);
            end
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(c);
        requests_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        cmd_t c;
        int unsigned i;
        int unsigned w_begin;
        int unsigned w_end;
        int unsigned pick;
        int unsigned kind;
        longint base;
        longint inc;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        idle_on = 1'b1;
        requests_sent = 0;
        cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stack, jumps and unused function codes.
        send_cmd(make_cmd(FN_AGAIN, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_READ_K, '1, S64_MAX, S64_MIN, '0, '1, '1));
        send_cmd(make_cmd(FN_JUMP_ZERO, '0, S64_MAX, S64_MIN, -64'sd1, '0, '1));
        send_cmd(make_cmd(FN_JUMP_ZERO, '1, '0, '0, '0, S64_MIN, 16'h1234));
        send_cmd(make_cmd(FN_JUMP, 16'h8001, '1, '1, '1, S64_MAX, '0));
        send_cmd(make_cmd(FN_UNUSED_TOP, '1, '1, '1, '1, '1, '1));

        // A ranged loop whose bound wraps, then one with the most negative step.
        send_cmd(make_cmd(FN_RANGED_BEGIN, '1, S64_MAX - 1, S64_MIN, 64'sd1, '0, '0));
        send_cmd(make_cmd(FN_NEXT, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_READ_I, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_AGAIN, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_RANGED_BEGIN, '0, '0, '0, S64_MIN, '0, '0));
        send_cmd(make_cmd(FN_AGAIN, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_AGAIN, '0, '0, '0, '0, '0, '0));

        // Fill the stack, read deep, and push past the top.
        for (i = 0; i < LOOP_DEPTH; i++)
        begin
            if (i % 2 == 0)
                send_cmd(make_cmd(FN_COUNTED_BEGIN, PC_WIDTH'(i), longint'(i % 3), '0, '0,
                                  '0, '0));
            else
                send_cmd(make_cmd(FN_RANGED_BEGIN, PC_WIDTH'(i), -longint'(i), -longint'(i),
                                  '0, '0, '0));
        end
        send_cmd(make_cmd(FN_READ_K, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_COUNTED_BEGIN, '1, S64_MAX, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_RANGED_BEGIN, '1, S64_MIN, S64_MAX, S64_MAX, '0, '0));
        send_cmd(make_cmd(FN_READ_J, '0, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(FN_NEXT, '0, '0, '0, '0, '0, '0));
        drain_results();

        while (requests_sent < ITEM_COUNT)
        begin
            idle_on = !(requests_sent >= 300 && requests_sent < 500);
            if (requests_sent == 650)
                drain_results();
            c = random_cmd();
            w_begin = (sb.live_frames >= LOOP_DEPTH) ? 4 : (sb.live_frames >= 5) ? 12 : 30;
            w_end = (sb.live_frames == 0) ? 4 : (sb.live_frames >= 5) ? 45 : 30;
            pick = $urandom_range(w_begin + w_end + 34);
            if (pick < w_begin)
            begin
                c.func = $urandom_range(1) ? FN_RANGED_BEGIN : FN_COUNTED_BEGIN;
                // A full stack ignores the push, so its fields may be anything.
                if (sb.live_frames < LOOP_DEPTH && c.func == FN_COUNTED_BEGIN)
                begin
                    if ($urandom_range(9) == 0)
                        c.count_or_start = -(longint'($urandom_range(2)) + 1);
                    else
                        c.count_or_start = longint'($urandom_range(5));
                end
                else if (sb.live_frames < LOOP_DEPTH)
                begin
                    kind = $urandom_range(9);
                    base = longint'($urandom_range(40)) - 20;
                    inc = longint'($urandom_range(2)) + 1;
                    if (kind < 7)
                    begin
                        if ($urandom_range(1))
                            inc = -inc;
                        c.count_or_start = base;
                        c.step = inc;
                        c.limit = base + inc * longint'($urandom_range(6))
                                  + longint'($urandom_range(4)) - 2;
                    end
                    else if (kind == 7)
                    begin
                        c.count_or_start = base;
                        c.step = '0;
                        c.limit = base + longint'($urandom_range(5));
                    end
                    else if (kind == 8)
                    begin
                        if ($urandom_range(1))
                        begin
                            c.count_or_start = S64_MAX - longint'($urandom_range(4));
                            c.step = inc;
                            c.limit = $urandom_range(1) ? S64_MAX : S64_MIN;
                        end
                        else
                        begin
                            c.count_or_start = S64_MIN + longint'($urandom_range(4));
                            c.step = -inc;
                            c.limit = $urandom_range(1) ? S64_MAX : S64_MIN;
                        end
                    end
                end
            end
            else if (pick < w_begin + w_end)
                c.func = $urandom_range(1) ? FN_AGAIN : FN_NEXT;
            else
            begin
                pick = $urandom_range(34);
                if (pick < 18)
                    c.func = (pick < 6) ? FN_READ_I : (pick < 12) ? FN_READ_J : FN_READ_K;
                else if (pick < 25)
                begin
                    c.func = FN_JUMP_ZERO;
                    if ($urandom_range(1))
                        c.condition = '0;
                end
                else if (pick < 31)
                    c.func = FN_JUMP;
                else
                    c.func = 4'($urandom_range(int'(FN_UNUSED_TOP), int'(FN_JUMP) + 1));
            end
            send_cmd(c);
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report("requests left without a result");
        if (sb.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_cell.sv
hw/rtl/loop_control_stack_core.sv
bench/loop_control_stack_core_tb.sv
